// File: design/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared codes, field widths and stream packing for the layer compositor.
// ----------------------------------------------------------------------------
package lpc_pkg;

    // Item kinds carried on s_tuser.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_LAYER_COUNT = 1'b0;
    localparam logic CFG_BACKGROUND  = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    // Fixed field widths of the stream items.
    localparam int IDX_W   = 4;
    localparam int FCRD_W  = 12;
    localparam int SCR_W   = 11;
    localparam int ADDR_W  = 32;
    localparam int COLOR_W = 32;
    localparam int CNT_W   = 5;

    localparam logic [COLOR_W-1:0] BG_RESET = 32'hFF00_8080;

    // Input tdata layout, lowest bit first.
    localparam int IN_IDX_LSB  = 0;
    localparam int IN_X_LSB    = IN_IDX_LSB + IDX_W;
    localparam int IN_Y_LSB    = IN_X_LSB + FCRD_W;
    localparam int IN_W_LSB    = IN_Y_LSB + FCRD_W;
    localparam int IN_H_LSB    = IN_W_LSB + FCRD_W;
    localparam int IN_VIS_LSB  = IN_H_LSB + FCRD_W;
    localparam int IN_BASE_LSB = IN_VIS_LSB + 1;
    localparam int IN_SX_LSB   = IN_BASE_LSB + ADDR_W;
    localparam int IN_SY_LSB   = IN_SX_LSB + SCR_W;
    localparam int IN_BITS     = IN_SY_LSB + SCR_W;
    localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int OUT_WIN_LSB  = 0;
    localparam int OUT_ADDR_LSB = OUT_WIN_LSB + IDX_W;
    localparam int OUT_FILL_LSB = OUT_ADDR_LSB + ADDR_W;
    localparam int OUT_BITS     = OUT_FILL_LSB + COLOR_W;
    localparam int M_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

endpackage

// File: design/lpc_table.sv
// ----------------------------------------------------------------------------
// lpc_table
// Layer table in flip-flops: rectangle, shown mark and base address per layer.
// ----------------------------------------------------------------------------
module lpc_table
    import lpc_pkg::*;
#(
    parameter int MAX_LAYERS = 16,
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_idx,
    input  logic [COORD_BITS-1:0] wr_x,
    input  logic [COORD_BITS-1:0] wr_y,
    input  logic [COORD_BITS-1:0] wr_w,
    input  logic [COORD_BITS-1:0] wr_h,
    input  logic                  wr_shown,
    input  logic [ADDR_W-1:0]     wr_base,
    output logic [COORD_BITS-1:0] tab_x     [MAX_LAYERS],
    output logic [COORD_BITS-1:0] tab_y     [MAX_LAYERS],
    output logic [COORD_BITS-1:0] tab_w     [MAX_LAYERS],
    output logic [COORD_BITS-1:0] tab_h     [MAX_LAYERS],
    output logic                  tab_shown [MAX_LAYERS],
    output logic [ADDR_W-1:0]     tab_base  [MAX_LAYERS]
);

    // An index at or above the table depth matches no entry and is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LAYERS; i++)
            begin
                tab_x[i]     <= '0;
                tab_y[i]     <= '0;
                tab_w[i]     <= '0;
                tab_h[i]     <= '0;
                tab_shown[i] <= 1'b0;
                tab_base[i]  <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < MAX_LAYERS; i++)
            begin
                if ({3'b000, wr_idx} == 7'(i))
                begin
                    tab_x[i]     <= wr_x;
                    tab_y[i]     <= wr_y;
                    tab_w[i]     <= wr_w;
                    tab_h[i]     <= wr_h;
                    tab_shown[i] <= wr_shown;
                    tab_base[i]  <= wr_base;
                end
            end
        end
    end

endmodule

// File: design/lpc_hit.sv
// ----------------------------------------------------------------------------
// lpc_hit
// Parallel rectangle test over all layers and selection of the top cover.
// ----------------------------------------------------------------------------
module lpc_hit
    import lpc_pkg::*;
#(
    parameter int MAX_LAYERS = 16,
    parameter int COORD_BITS = 12
)
(
    input  logic [SCR_W-1:0]      sx,
    input  logic [SCR_W-1:0]      sy,
    input  logic [CNT_W-1:0]      layer_count,
    input  logic [COORD_BITS-1:0] tab_x     [MAX_LAYERS],
    input  logic [COORD_BITS-1:0] tab_y     [MAX_LAYERS],
    input  logic [COORD_BITS-1:0] tab_w     [MAX_LAYERS],
    input  logic [COORD_BITS-1:0] tab_h     [MAX_LAYERS],
    input  logic                  tab_shown [MAX_LAYERS],
    input  logic [ADDR_W-1:0]     tab_base  [MAX_LAYERS],
    output logic                  hit,
    output logic [IDX_W-1:0]      win_idx,
    output logic [COORD_BITS-1:0] win_row,
    output logic [COORD_BITS-1:0] win_col,
    output logic [COORD_BITS-1:0] win_width,
    output logic [ADDR_W-1:0]     win_base
);

    // Signed compare width holds the screen range and a layer's far edge.
    localparam int W = ((COORD_BITS > SCR_W) ? COORD_BITS : SCR_W) + 2;

    logic signed [W-1:0]     sx_s;
    logic signed [W-1:0]     sy_s;
    logic                    layer_hit [MAX_LAYERS];
    logic [COORD_BITS-1:0]   layer_row [MAX_LAYERS];
    logic [COORD_BITS-1:0]   layer_col [MAX_LAYERS];

    assign sx_s = $signed({{(W-SCR_W){1'b0}}, sx});
    assign sy_s = $signed({{(W-SCR_W){1'b0}}, sy});

    always_comb
    begin
        logic signed [W-1:0] lx;
        logic signed [W-1:0] ly;
        logic signed [W-1:0] lw;
        logic signed [W-1:0] lh;
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        logic                active;
        for (int i = 0; i < MAX_LAYERS; i++)
        begin
            lx = W'($signed(tab_x[i]));
            ly = W'($signed(tab_y[i]));
            lw = $signed({{(W-COORD_BITS){1'b0}}, tab_w[i]});
            lh = $signed({{(W-COORD_BITS){1'b0}}, tab_h[i]});
            dx = sx_s - lx;
            dy = sy_s - ly;
            // A count above the table depth enables every entry.
            active = ({2'b00, layer_count} > 7'(i)) && tab_shown[i];
            layer_hit[i] = active && (sx_s >= lx) && (sx_s < lx + lw)
                                  && (sy_s >= ly) && (sy_s < ly + lh);
            layer_row[i] = dy[COORD_BITS-1:0];
            layer_col[i] = dx[COORD_BITS-1:0];
        end
    end

    // Later entries override earlier ones, so the highest index wins.
    always_comb
    begin
        hit       = 1'b0;
        win_idx   = '0;
        win_row   = '0;
        win_col   = '0;
        win_width = '0;
        win_base  = '0;
        for (int i = 0; i < MAX_LAYERS; i++)
        begin
            if (layer_hit[i])
            begin
                hit       = 1'b1;
                win_idx   = IDX_W'(i);
                win_row   = layer_row[i];
                win_col   = layer_col[i];
                win_width = tab_w[i];
                win_base  = tab_base[i];
            end
        end
    end

endmodule

// File: design/lpc_addr.sv
// ----------------------------------------------------------------------------
// lpc_addr
// Source pixel address: base plus row times stride plus column.
// ----------------------------------------------------------------------------
module lpc_addr
    import lpc_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  covered,
    input  logic [COORD_BITS-1:0] row,
    input  logic [COORD_BITS-1:0] col,
    input  logic [COORD_BITS-1:0] width,
    input  logic [ADDR_W-1:0]     base,
    output logic [ADDR_W-1:0]     addr
);

    logic [2*COORD_BITS-1:0] prod;

    assign prod = row * width;
    assign addr = covered ? (base + ADDR_W'(prod) + ADDR_W'(col)) : '0;

endmodule

// File: design/layer_priority_compositor.sv
// ----------------------------------------------------------------------------
// layer_priority_compositor
// Overlay layer mixer: picks the top visible layer under a screen pixel.
// ----------------------------------------------------------------------------
// The block takes one item per clock while s_tready is high. A query passes an
// input register, a compare stage that tests the pixel against every layer of
// the flip-flop table in parallel and keeps the highest covering one, and an
// address stage whose single multiplier forms row times stride before the
// result register. A write item waits in the input register, updates the table
// as it leaves, and gives no result; a query that follows it sees the new
// entry. Backpressure on the result side lets empty stages fill, so s_tready
// falls only when all three registers are full.
// ----------------------------------------------------------------------------
module layer_priority_compositor
    import lpc_pkg::*;
#(
    parameter int MAX_LAYERS = 16,
    parameter int COORD_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // layer_index, layer_x, layer_y, layer_width, layer_height,
    // layer_visible, layer_base, screen_x, screen_y, zero pad
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // action
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // winning_layer, source_address, fill_color, zero pad
    output logic [M_TDATA_W-1:0]   m_tdata,
    // covered
    output logic                   m_tuser
);

    logic [CNT_W-1:0]      layer_count_reg;
    logic [COLOR_W-1:0]    background_reg;

    logic                  in_valid_reg;
    logic                  in_action_reg;
    logic [IN_BITS-1:0]    in_data_reg;

    logic                  mid_valid_reg;
    logic                  mid_covered_reg;
    logic [IDX_W-1:0]      mid_layer_reg;
    logic [COORD_BITS-1:0] mid_row_reg;
    logic [COORD_BITS-1:0] mid_col_reg;
    logic [COORD_BITS-1:0] mid_width_reg;
    logic [ADDR_W-1:0]     mid_base_reg;
    logic [COLOR_W-1:0]    mid_fill_reg;

    logic                  out_valid_reg;
    logic                  out_covered_reg;
    logic [IDX_W-1:0]      out_layer_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [COLOR_W-1:0]    out_fill_reg;

    logic                  out_load;
    logic                  mid_load;
    logic                  in_free;
    logic                  tab_wr;

    logic [COORD_BITS-1:0] tab_x     [MAX_LAYERS];
    logic [COORD_BITS-1:0] tab_y     [MAX_LAYERS];
    logic [COORD_BITS-1:0] tab_w     [MAX_LAYERS];
    logic [COORD_BITS-1:0] tab_h     [MAX_LAYERS];
    logic                  tab_shown [MAX_LAYERS];
    logic [ADDR_W-1:0]     tab_base  [MAX_LAYERS];

    logic                  hit;
    logic [IDX_W-1:0]      win_idx;
    logic [COORD_BITS-1:0] win_row;
    logic [COORD_BITS-1:0] win_col;
    logic [COORD_BITS-1:0] win_width;
    logic [ADDR_W-1:0]     win_base;
    logic [ADDR_W-1:0]     addr_next;

    // Each stage loads when it is empty or its content moves on.
    assign out_load = !out_valid_reg || m_tready;
    assign mid_load = !mid_valid_reg || out_load;
    assign in_free  = !in_valid_reg || (in_action_reg == ACT_WRITE) || mid_load;
    assign s_tready = in_free;
    assign tab_wr   = in_valid_reg && (in_action_reg == ACT_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_count_reg <= '0;
            background_reg  <= BG_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LAYER_COUNT: layer_count_reg <= cfg_wdata[CNT_W-1:0];
                CFG_BACKGROUND:  background_reg  <= cfg_wdata[COLOR_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (mid_load)
            begin
                mid_valid_reg <= in_valid_reg && (in_action_reg == ACT_QUERY);
            end
            if (out_load)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free)
        begin
            in_action_reg <= s_tuser;
            in_data_reg   <= s_tdata[IN_BITS-1:0];
        end
        if (mid_load)
        begin
            mid_covered_reg <= hit;
            mid_layer_reg   <= win_idx;
            mid_row_reg     <= win_row;
            mid_col_reg     <= win_col;
            mid_width_reg   <= win_width;
            mid_base_reg    <= win_base;
            mid_fill_reg    <= hit ? '0 : background_reg;
        end
        if (out_load)
        begin
            out_covered_reg <= mid_covered_reg;
            out_layer_reg   <= mid_layer_reg;
            out_addr_reg    <= addr_next;
            out_fill_reg    <= mid_fill_reg;
        end
    end

    lpc_table #(
        .MAX_LAYERS (MAX_LAYERS),
        .COORD_BITS (COORD_BITS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (tab_wr),
        .wr_idx    (in_data_reg[IN_IDX_LSB +: IDX_W]),
        .wr_x      (COORD_BITS'(in_data_reg[IN_X_LSB +: FCRD_W])),
        .wr_y      (COORD_BITS'(in_data_reg[IN_Y_LSB +: FCRD_W])),
        .wr_w      (COORD_BITS'(in_data_reg[IN_W_LSB +: FCRD_W])),
        .wr_h      (COORD_BITS'(in_data_reg[IN_H_LSB +: FCRD_W])),
        .wr_shown  (in_data_reg[IN_VIS_LSB]),
        .wr_base   (in_data_reg[IN_BASE_LSB +: ADDR_W]),
        .tab_x     (tab_x),
        .tab_y     (tab_y),
        .tab_w     (tab_w),
        .tab_h     (tab_h),
        .tab_shown (tab_shown),
        .tab_base  (tab_base)
    );

    lpc_hit #(
        .MAX_LAYERS (MAX_LAYERS),
        .COORD_BITS (COORD_BITS)
    ) u_hit (
        .sx          (in_data_reg[IN_SX_LSB +: SCR_W]),
        .sy          (in_data_reg[IN_SY_LSB +: SCR_W]),
        .layer_count (layer_count_reg),
        .tab_x       (tab_x),
        .tab_y       (tab_y),
        .tab_w       (tab_w),
        .tab_h       (tab_h),
        .tab_shown   (tab_shown),
        .tab_base    (tab_base),
        .hit         (hit),
        .win_idx     (win_idx),
        .win_row     (win_row),
        .win_col     (win_col),
        .win_width   (win_width),
        .win_base    (win_base)
    );

    lpc_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .covered (mid_covered_reg),
        .row     (mid_row_reg),
        .col     (mid_col_reg),
        .width   (mid_width_reg),
        .base    (mid_base_reg),
        .addr    (addr_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_covered_reg;
    assign m_tdata  = M_TDATA_W'({out_fill_reg, out_addr_reg, out_layer_reg});

    // An uncovered result carries neither a layer nor an address.
    a_uncovered_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_covered_reg)
            |-> (out_addr_reg == '0) && (out_layer_reg == '0))
        else $error("uncovered result with nonzero layer or address");

    // A covered result carries no fill color.
    a_covered_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_covered_reg) |-> (out_fill_reg == '0))
        else $error("covered result with nonzero fill color");

    // A write item never turns into a result.
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && (in_action_reg == ACT_WRITE) && mid_load)
            |=> !mid_valid_reg)
        else $error("write item entered the compare stage");

    // Input stalls only when every stage is full and the output is held.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && mid_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

endmodule

// File: bench/layer_priority_compositor_checker.sv
// ----------------------------------------------------------------------------
// layer_priority_compositor_checker
// Watches the compositor's ports, predicts every pixel result and compares.
// ----------------------------------------------------------------------------
// The checker keeps its own copy of the layer table and of the two registers.
// It learns them from the accepted write items and register writes. Each
// accepted query is composed against that copy, and the outcome waits in a
// queue until the block hands back its result.
// ----------------------------------------------------------------------------
module layer_priority_compositor_checker
    import lpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   m_tuser,
    output int                     mismatches,
    output int                     pending,
    output int                     results_seen,
    output int                     hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    // A broken block could flood the log, so only the first mismatches print.
    localparam int PRINT_CAP   = 60;

    typedef struct packed {
        logic               hit;
        logic [IDX_W-1:0]   layer;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] fill;
    } pixel_result_t;

    logic signed [FCRD_W-1:0] lay_x    [TABLE_DEPTH];
    logic signed [FCRD_W-1:0] lay_y    [TABLE_DEPTH];
    logic        [FCRD_W-1:0] lay_w    [TABLE_DEPTH];
    logic        [FCRD_W-1:0] lay_h    [TABLE_DEPTH];
    logic                     lay_on   [TABLE_DEPTH];
    logic        [ADDR_W-1:0] lay_base [TABLE_DEPTH];
    logic        [CNT_W-1:0]  layer_total;
    logic        [COLOR_W-1:0] backdrop;

    pixel_result_t expected_pixels[$];
    pixel_result_t got;
    pixel_result_t want;
    logic [IDX_W-1:0] slot;
    int err_count = 0;
    int result_count = 0;
    int hit_count = 0;

    assign mismatches   = err_count;
    assign results_seen = result_count;
    assign hits_seen    = hit_count;

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("%0t ns: mismatch on %s: got %h, expected %h",
                     $time, what, seen, wanted);
    endtask

    // Topmost visible layer under the pixel; background when none covers it.
    function automatic pixel_result_t compose_pixel(input logic [SCR_W-1:0] col_in,
                                                    input logic [SCR_W-1:0] row_in);
        pixel_result_t res;
        int px;
        int py;
        int lx;
        int ly;
        int lw;
        int lh;
        int live;
        logic [ADDR_W-1:0] row;
        logic [ADDR_W-1:0] col;
        logic [ADDR_W-1:0] stride;
        res  = '0;
        px   = int'(col_in);
        py   = int'(row_in);
        live = (layer_total > TABLE_DEPTH) ? TABLE_DEPTH : int'(layer_total);
        for (int i = 0; i < live; i++)
        begin
            lx = int'(lay_x[i]);
            ly = int'(lay_y[i]);
            lw = int'(lay_w[i]);
            lh = int'(lay_h[i]);
            if (lay_on[i] && px >= lx && px < lx + lw && py >= ly && py < ly + lh)
            begin
                row       = py - ly;
                col       = px - lx;
                stride    = lw;
                res.hit   = 1'b1;
                res.layer = i[IDX_W-1:0];
                res.addr  = lay_base[i] + row * stride + col;
            end
        end
        if (!res.hit)
            res.fill = backdrop;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                lay_x[i]    = '0;
                lay_y[i]    = '0;
                lay_w[i]    = '0;
                lay_h[i]    = '0;
                lay_on[i]   = 1'b0;
                lay_base[i] = '0;
            end
            layer_total = '0;
            backdrop    = BG_RESET;
            expected_pixels.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.hit   = m_tuser;
                got.layer = m_tdata[OUT_WIN_LSB +: IDX_W];
                got.addr  = m_tdata[OUT_ADDR_LSB +: ADDR_W];
                got.fill  = m_tdata[OUT_FILL_LSB +: COLOR_W];
                result_count++;
                if (got.hit)
                    hit_count++;
                if (expected_pixels.size() == 0)
                    report_mismatch("result with no query waiting", got.addr, '0);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch("covered", 32'(got.hit), 32'(want.hit));
                    if (got.layer !== want.layer)
                        report_mismatch("winning_layer", 32'(got.layer), 32'(want.layer));
                    if (got.addr !== want.addr)
                        report_mismatch("source_address", got.addr, want.addr);
                    if (got.fill !== want.fill)
                        report_mismatch("fill_color", got.fill, want.fill);
                end
            end

            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_LAYER_COUNT)
                    layer_total = cfg_wdata[CNT_W-1:0];
                else if (cfg_index == CFG_BACKGROUND)
                    backdrop = cfg_wdata[COLOR_W-1:0];
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ACT_WRITE)
                begin
                    slot           = s_tdata[IN_IDX_LSB +: IDX_W];
                    lay_x[slot]    = s_tdata[IN_X_LSB +: FCRD_W];
                    lay_y[slot]    = s_tdata[IN_Y_LSB +: FCRD_W];
                    lay_w[slot]    = s_tdata[IN_W_LSB +: FCRD_W];
                    lay_h[slot]    = s_tdata[IN_H_LSB +: FCRD_W];
                    lay_on[slot]   = s_tdata[IN_VIS_LSB];
                    lay_base[slot] = s_tdata[IN_BASE_LSB +: ADDR_W];
                end
                else
                    expected_pixels.push_back(compose_pixel(s_tdata[IN_SX_LSB +: SCR_W],
                                                            s_tdata[IN_SY_LSB +: SCR_W]));
            end
            pending <= expected_pixels.size();
        end
    end

endmodule

// File: bench/layer_priority_compositor_test.sv
// ----------------------------------------------------------------------------
// layer_priority_compositor_test
// Stimulus and verdict for the overlay layer compositor.
// ----------------------------------------------------------------------------
// A directed run first covers table extremes, hidden and empty layers, an
// oversized layer whose address wraps, and a layer count above the table.
// Six random phases follow, each under its own register setting and one of
// three idling patterns. Layer writes are mostly sane rectangles and queries mostly aim at
// the written layers, so edges and overlaps are hit often. The checker beside
// the block predicts and compares; this module only drives and judges.
// ----------------------------------------------------------------------------
module layer_priority_compositor_test
    import lpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS    = 255;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SCREEN_MAX     = 2047;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;

    int mismatches;
    int pending;
    int results_seen;
    int hits_seen;

    int snd_idle_pct = 24;
    int rcv_idle_pct = 71;
    bit hold_req = 1'b0;
    int idle_cycles = 0;
    int write_items = 0;
    int query_items = 0;
    int reg_writes = 0;
    int count_now = 0;

    // Last geometry written per layer, used only to aim queries.
    int aim_x [16];
    int aim_y [16];
    int aim_w [16];
    int aim_h [16];

    layer_priority_compositor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    layer_priority_compositor_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen),
        .hits_seen    (hits_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Result side: random stalls, or one long hold-off when asked for.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: nothing moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Random content in every field, zero pad; each item overwrites its own fields.
    function automatic logic [S_TDATA_W-1:0] noise_payload();
        logic [S_TDATA_W-1:0] d;
        d = S_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
        d[S_TDATA_W-1:IN_BITS] = '0;
        return d;
    endfunction

    function automatic int clamp_screen(input int v);
        if (v < 0)
            return 0;
        if (v > SCREEN_MAX)
            return SCREEN_MAX;
        return v;
    endfunction

    task automatic send_item(input logic act, input logic [S_TDATA_W-1:0] data);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_layer(input int idx, input int x, input int y, input int w,
                               input int h, input logic vis, input logic [31:0] base);
        logic [S_TDATA_W-1:0] d;
        d = noise_payload();
        d[IN_IDX_LSB +: IDX_W]   = idx[IDX_W-1:0];
        d[IN_X_LSB +: FCRD_W]    = x[FCRD_W-1:0];
        d[IN_Y_LSB +: FCRD_W]    = y[FCRD_W-1:0];
        d[IN_W_LSB +: FCRD_W]    = w[FCRD_W-1:0];
        d[IN_H_LSB +: FCRD_W]    = h[FCRD_W-1:0];
        d[IN_VIS_LSB]            = vis;
        d[IN_BASE_LSB +: ADDR_W] = base;
        aim_x[idx] = x;
        aim_y[idx] = y;
        aim_w[idx] = w;
        aim_h[idx] = h;
        write_items++;
        send_item(ACT_WRITE, d);
    endtask

    task automatic query_pixel(input int sx, input int sy);
        logic [S_TDATA_W-1:0] d;
        d = noise_payload();
        d[IN_SX_LSB +: SCR_W] = sx[SCR_W-1:0];
        d[IN_SY_LSB +: SCR_W] = sy[SCR_W-1:0];
        query_items++;
        send_item(ACT_QUERY, d);
    endtask

    // Stop offering, let every expected result drain, then let write items
    // still in the pipeline leave it.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The enable drops for one cycle after every write, so back-to-back
    // register writes never touch the enable twice at the same edge.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx == CFG_LAYER_COUNT)
            count_now = int'(val[CNT_W-1:0]);
        reg_writes++;
    endtask

    task automatic random_write();
        int idx;
        int x;
        int y;
        int w;
        int h;
        logic vis;
        idx = $urandom_range(0, 15);
        if ($urandom_range(0, 99) < 85)
        begin
            x   = int'($urandom_range(0, 2300)) - 250;
            y   = int'($urandom_range(0, 2300)) - 250;
            w   = $urandom_range(1, 700);
            h   = $urandom_range(1, 700);
            vis = ($urandom_range(0, 99) < 80);
        end
        else
        begin
            x   = int'($urandom_range(0, 4095)) - 2048;
            y   = int'($urandom_range(0, 4095)) - 2048;
            w   = $urandom_range(0, 4095);
            h   = $urandom_range(0, 4095);
            vis = 1'($urandom_range(0, 1));
        end
        write_layer(idx, x, y, w, h, vis, $urandom);
    endtask

    // Most queries land on or just around a layer that takes part.
    task automatic random_query();
        int k;
        int lim;
        if ($urandom_range(0, 99) < 80)
        begin
            lim = (count_now < 1) ? 1 : ((count_now > 16) ? 16 : count_now);
            k   = $urandom_range(0, lim - 1);
            query_pixel(clamp_screen(aim_x[k] + int'($urandom_range(0, aim_w[k] + 3)) - 2),
                        clamp_screen(aim_y[k] + int'($urandom_range(0, aim_h[k] + 3)) - 2));
        end
        else
            query_pixel($urandom_range(0, SCREEN_MAX), $urandom_range(0, SCREEN_MAX));
    endtask

    initial
    begin
        int counts [6];
        int colors [6];
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_LAYER_COUNT;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= ACT_WRITE;
        s_tdata   <= '0;
        for (int i = 0; i < 16; i++)
        begin
            aim_x[i] = 0;
            aim_y[i] = 0;
            aim_w[i] = 0;
            aim_h[i] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset background, full-screen and corner layers, empty
        // layers, a wrapping oversized layer, hidden layers, count limits.
        query_pixel(0, 0);
        settle();
        write_reg(CFG_LAYER_COUNT, 31);
        write_layer(0, 0, 0, 2048, 2048, 1'b1, 32'h1000_0000);
        query_pixel(0, 0);
        query_pixel(SCREEN_MAX, SCREEN_MAX);
        write_layer(8, 100, 100, 0, 50, 1'b1, 32'h0000_0000);
        write_layer(9, 100, 100, 50, 0, 1'b1, 32'h0000_0000);
        query_pixel(100, 100);
        write_layer(7, 2047, 2047, 1, 1, 1'b1, 32'hABCD_0000);
        query_pixel(SCREEN_MAX, SCREEN_MAX);
        write_layer(15, -2048, -2048, 4095, 4095, 1'b1, 32'hFFFF_FFF0);
        query_pixel(2046, 2046);
        query_pixel(SCREEN_MAX, SCREEN_MAX);
        query_pixel(0, 0);
        write_layer(12, 2047, 0, 2048, 2048, 1'b0, 32'hFFFF_FFFF);
        write_layer(15, -2048, -2048, 4095, 4095, 1'b0, 32'hFFFF_FFF0);
        query_pixel(SCREEN_MAX, 0);
        settle();
        write_reg(CFG_LAYER_COUNT, 7);
        query_pixel(SCREEN_MAX, SCREEN_MAX);
        settle();
        write_reg(CFG_LAYER_COUNT, 0);
        write_reg(CFG_BACKGROUND, 32'hFFFF_FFFF);
        query_pixel(5, 5);

        counts = '{16, 31, 5, 1, 17, 0};
        counts[5] = $urandom_range(0, 16);
        colors = '{0, 0, 0, 0, 0, 0};
        colors[0] = $urandom;
        colors[2] = $urandom;
        colors[3] = 32'hFFFF_FFFF;
        colors[4] = $urandom;
        colors[5] = BG_RESET;

        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            write_reg(CFG_LAYER_COUNT, counts[ph]);
            write_reg(CFG_BACKGROUND, colors[ph]);
            case (ph % 3)
                0:
                begin
                    snd_idle_pct = 24;
                    rcv_idle_pct = 71;
                end
                1:
                begin
                    snd_idle_pct = 71;
                    rcv_idle_pct = 24;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // With both sides eager, a long receiver hold fills the pipe.
                if (ph == 2 && n == 60)
                    hold_req = 1'b1;
                if ($urandom_range(0, 99) < 25)
                    random_write();
                else
                    random_query();
            end
        end

        settle();
        $display("Run covered %0d items: %0d layer writes and %0d pixel queries,",
                 write_items + query_items, write_items, query_items);
        $display("%0d register writes, %0d results compared, %0d on a covering layer.",
                 reg_writes, results_seen, hits_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
